### rtl/qlea_pkg.sv
`default_nettype none
package qlea_pkg;

  localparam int NET_LEVELS = 6;

  typedef enum logic [1:0] {
    MODE_SET    = 2'd0,
    MODE_CHOOSE = 2'd1,
    MODE_FEED   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_LEARN   = 2'd0,
    CFG_DISC    = 2'd1,
    CFG_EXPLORE = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_PICK,
    S_RDQ,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_WRITE,
    S_OUT
  } fsm_t;

  localparam logic [15:0] LEARN_RESET   = 16'd6554;
  localparam logic [15:0] DISC_RESET    = 16'd52429;
  localparam logic [15:0] EXPLORE_RESET = 16'd13107;

  function automatic logic [2:0] net_class(input logic [6:0] load);
    if (load < 7'd30)      return 3'd5;
    else if (load < 7'd50) return 3'd4;
    else if (load < 7'd70) return 3'd3;
    else if (load < 7'd80) return 3'd2;
    else if (load < 7'd90) return 3'd1;
    else                   return 3'd0;
  endfunction

endpackage
`default_nettype wire

### rtl/q_learning_epsilon_greedy_agent.sv
// channel | valid    | ready    | payload
// in      | in_valid | in_ready | mode, poa_grade, network_load_pct, satisfaction_level,
//         |          |          | handover_count, rand_explore, rand_pick
// out     | out_valid| out_ready| action, state_index, reward, updated_value, accepted
// cfg     | cfg_we   | -        | cfg_index, cfg_data
// after reset the table of STATES*NUM_ACTIONS entries (396 with default parameters) is cleared one entry per cycle
// an exploiting choice makes two row passes: a scan for the maximum, then a pick among the ties
// feedback: one row pass, a read of the chosen entry, 3 multiply steps, one write
// set, random choice, ignored mode and rejected feedback go straight from idle to the result
// one item at a time; a held result blocks the next item until it is taken
`default_nettype none
module q_learning_epsilon_greedy_agent
  import qlea_pkg::*;
#(
  parameter int POA_LEVELS  = 6,
  parameter int NUM_ACTIONS = 11,
  parameter int VALUE_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [15:0]            cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             mode,
  input  wire logic [6:0]             poa_grade,
  input  wire logic [6:0]             network_load_pct,
  input  wire logic [15:0]            satisfaction_level,
  input  wire logic [7:0]             handover_count,
  input  wire logic [15:0]            rand_explore,
  input  wire logic [15:0]            rand_pick,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [3:0]                  action,
  output logic [5:0]                  state_index,
  output logic signed [9:0]           reward,
  output logic signed [VALUE_WIDTH-1:0] updated_value,
  output logic                        accepted
);

  localparam int STATES = NET_LEVELS * POA_LEVELS;
  localparam int DEPTH  = STATES * NUM_ACTIONS;
  localparam int AW     = $clog2(DEPTH);
  localparam int SW     = $clog2(STATES);
  localparam int ACW    = $clog2(NUM_ACTIONS + 1);
  localparam int TW     = VALUE_WIDTH + 20;
  localparam int SUMW   = VALUE_WIDTH + 6;
  localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic signed [VALUE_WIDTH-1:0] mem [DEPTH];
  logic signed [VALUE_WIDTH-1:0] rdata;
  logic [AW-1:0] raddr, waddr;
  logic we;
  logic signed [VALUE_WIDTH-1:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  fsm_t state, state_next;
  logic [15:0] learn_rate, discount, explore_prob;
  logic [SW-1:0] cur_state;
  logic [3:0] chosen;
  logic awaiting;
  logic [6:0] last_grade, last_load;
  logic [15:0] last_sat;

  logic [AW-1:0] clr_cnt;
  logic [ACW-1:0] cnt;
  logic pass2, rvalid;
  logic [ACW-1:0] ties, k;
  logic signed [VALUE_WIDTH-1:0] rmax, q;
  logic [SW-1:0] row, next_st;
  logic [1:0] m_mode;
  logic [6:0] m_grade, m_load;
  logic [15:0] m_sat, m_pick;
  logic [7:0] m_hos;
  logic signed [9:0] rew;
  logic signed [TW-1:0] t;
  logic [TW-1:0] mag;
  logic [TW+15:0] prod;
  logic [3:0] pick_a;
  logic signed [VALUE_WIDTH+16:0] gq;

  logic [SW-1:0] quant;
  always_comb begin
    logic [3:0] g;
    g = 4'((8'(poa_grade) + 8'd8) >> 4);
    if (g > 4'(POA_LEVELS - 1)) g = 4'(POA_LEVELS - 1);
    quant = SW'(POA_LEVELS * int'(net_class(network_load_pct)) + int'(g));
  end

  assign pick_a = 4'((32'(NUM_ACTIONS) * 32'(rand_pick)) >> 16);
  assign gq = $signed({1'b0, discount}) * rmax;

  logic [AW-1:0] row_base;
  assign row_base = AW'(int'(row) * NUM_ACTIONS);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (int'(clr_cnt) == DEPTH - 1) state_next = S_IDLE;
      S_IDLE: if (in_valid) begin
        if (mode == MODE_CHOOSE && rand_explore < explore_prob) state_next = S_OUT;
        else if (mode == MODE_CHOOSE || (mode == MODE_FEED && awaiting)) state_next = S_SCAN;
        else state_next = S_OUT;
      end
      S_SCAN: if (rvalid && int'(cnt) == NUM_ACTIONS) begin
        state_next = (m_mode == MODE_CHOOSE) ? S_PICK : S_RDQ;
      end
      S_PICK: if (rvalid && int'(cnt) == NUM_ACTIONS) state_next = S_OUT;
      S_RDQ: if (rvalid) state_next = S_MUL1;
      S_MUL1: state_next = S_MUL2;
      S_MUL2: state_next = S_MUL3;
      S_MUL3: state_next = S_WRITE;
      S_WRITE: state_next = S_OUT;
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    raddr = row_base + AW'(cnt);
    if (state == S_RDQ) raddr = AW'(int'(cur_state) * NUM_ACTIONS) + AW'(chosen);
  end

  logic signed [SUMW-1:0] sum;
  assign sum = SUMW'(q) + (t[TW-1] ? -$signed({1'b0, prod[TW+15:32]})
                                   : $signed({1'b0, prod[TW+15:32]}));
  always_comb begin
    we = 1'b0;
    waddr = AW'(int'(cur_state) * NUM_ACTIONS) + AW'(chosen);
    wdata = '0;
    if (state == S_CLEAR) begin
      we = 1'b1;
      waddr = clr_cnt;
    end else if (state == S_WRITE) begin
      we = 1'b1;
      if (sum > SUMW'(VMAX)) wdata = VMAX;
      else if (sum < SUMW'(VMIN)) wdata = VMIN;
      else wdata = sum[VALUE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      learn_rate <= LEARN_RESET;
      discount <= DISC_RESET;
      explore_prob <= EXPLORE_RESET;
      cur_state <= '0;
      chosen <= '0;
      awaiting <= 1'b0;
      last_grade <= '0;
      last_load <= '0;
      last_sat <= '0;
      cnt <= '0;
      rvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_LEARN: learn_rate <= cfg_data;
          CFG_DISC: discount <= cfg_data;
          CFG_EXPLORE: explore_prob <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      // read data is registered and good in the cycle after its address; the entry read waits for it
      rvalid <= (state_next == S_SCAN) || (state_next == S_PICK) || (state == S_RDQ);
      unique case (state)
        S_IDLE: if (in_valid) begin
          m_mode <= mode; m_grade <= poa_grade; m_load <= network_load_pct;
          m_sat <= satisfaction_level; m_hos <= handover_count; m_pick <= rand_pick;
          next_st <= quant;
          row <= (mode == MODE_FEED) ? quant : cur_state;
          cnt <= '0; ties <= '0;
          action <= (mode == MODE_CHOOSE && rand_explore < explore_prob) ? pick_a : '0;
          reward <= '0; updated_value <= '0;
          accepted <= !(mode == MODE_FEED && !awaiting);
          unique case (mode)
            MODE_SET: begin
              last_grade <= poa_grade; last_load <= network_load_pct; cur_state <= quant;
            end
            MODE_CHOOSE: if (rand_explore < explore_prob) begin
              chosen <= pick_a; awaiting <= 1'b1;
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          if (cnt != '0) begin
            if (cnt == ACW'(1) || rdata > rmax) begin rmax <= rdata; ties <= ACW'(1); end
            else if (rdata == rmax) ties <= ties + 1'b1;
          end
          if (int'(cnt) < NUM_ACTIONS) cnt <= cnt + 1'b1;
          if (rvalid && int'(cnt) == NUM_ACTIONS) begin
            cnt <= '0;
            k <= '0;
            rew <= 10'sd1 - 10'(signed'({1'b0, m_hos, 1'b0}))
                 + ((m_grade > last_grade) ? 10'sd10 : 10'sd0)
                 + ((m_load >= last_load) ? 10'sd10 : 10'sd0)
                 + ((m_sat >= last_sat) ? 10'sd10 : 10'sd0);
          end
        end
        S_PICK: begin
          if (cnt == '0) k <= ACW'((32'(ties) * 32'(m_pick)) >> 16);
          else if (rdata == rmax) begin
            if (k == '0 && !pass2) begin
              chosen <= 4'(cnt - 1'b1); action <= 4'(cnt - 1'b1);
            end
            k <= k - 1'b1;
          end
          if (int'(cnt) < NUM_ACTIONS) cnt <= cnt + 1'b1;
          if (rvalid && int'(cnt) == NUM_ACTIONS) awaiting <= 1'b1;
        end
        S_RDQ: if (rvalid) q <= rdata;
        S_MUL1: t <= ((TW'(rew) - TW'(q)) <<< 16) + TW'(gq);
        S_MUL2: mag <= t[TW-1] ? TW'(-t) : TW'(t);
        S_MUL3: prod <= (TW+16)'(mag) * (TW+16)'(learn_rate);
        S_WRITE: begin
          updated_value <= wdata; reward <= rew;
          cur_state <= next_st; last_grade <= m_grade; last_load <= m_load;
          last_sat <= m_sat; awaiting <= 1'b0;
        end
        default: ;
      endcase
      pass2 <= (state == S_PICK) && (pass2 || (cnt != '0 && rdata == rmax && k == '0));
    end
  end

  assign state_index = 6'(cur_state);

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped");
  a_no_both: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("ready during result");
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_WRITE |=> out_valid)
    else $error("write not followed by result");

endmodule
`default_nettype wire
